### hdl/spi_frame_parser_crc8_top_macros.svh
// Assertion macros for the SPI frame parser.
// Included by the RTL files that carry assertions; needs i_clk and i_rst_n in scope.
`ifndef SPI_FRAME_PARSER_CRC8_TOP_MACROS_SVH
`define SPI_FRAME_PARSER_CRC8_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SFP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SFP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SFP_ASSERT_IMP(lbl, ante, cons, msg)
`define SFP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### hdl/sfp_pkg.sv
// Shared types, constants and the CRC-8 step for the SPI frame parser.
// No dependencies.
package sfp_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int IDX_W       = $clog2(MAX_PAYLOAD);
    localparam int LEN_W       = 6;
    localparam int MEM_DEPTH   = 2 * MAX_PAYLOAD;
    localparam int MEM_AW      = IDX_W + 1;
    localparam int CMDQ_DEPTH  = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;

    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_INIT = 8'h00;

    typedef enum logic [1:0] {
        ST_PAYLOAD = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_CRC_ERR = 2'd2,
        ST_RAW     = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PREFIX = 1'b0,
        CFG_RAW    = 1'b1
    } t_cfg_idx;

    // one queued request for the drain side
    typedef struct packed {
        t_status          status;
        logic [7:0]       addr;
        logic [LEN_W-1:0] len;
        logic [7:0]       pb;
        logic [7:0]       crc;
        logic             bank;
    } t_cmd;

    typedef struct packed {
        logic              valid;
        logic [MEM_AW-1:0] addr;
        logic [7:0]        data;
    } t_mem_wr;

    typedef struct packed {
        logic valid;
        logic bank;
    } t_bank_rel;

    // CRC-8, MSB first
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### hdl/sfp_front.sv
// Front end: config registers, byte-level deframing, CRC and payload bank control.
// Depends on sfp_pkg and the assertion macro header.
`include "spi_frame_parser_crc8_top_macros.svh"

module sfp_front import sfp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wen,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_rx_valid,
    output logic                  o_rx_ready,
    input  logic [7:0]            i_rx_byte,
    output logic                  o_cmd_push,
    output t_cmd                  o_cmd,
    input  logic                  i_q_full,
    output t_mem_wr               o_mem_wr,
    input  t_bank_rel             i_rel
);

    typedef enum logic [4:0] {
        PH_HUNT = 5'b00001,
        PH_ADDR = 5'b00010,
        PH_LEN  = 5'b00100,
        PH_DATA = 5'b01000,
        PH_CRC  = 5'b10000
    } t_phase;

    logic [7:0]       r_prefix;
    logic             r_raw;
    t_phase           r_phase, n_phase;
    logic [7:0]       r_addr, n_addr;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_fill, n_fill;
    logic [7:0]       r_crc, n_crc;
    logic             r_wbank, n_wbank;
    logic [1:0]       r_busy, n_busy;
    logic             w_accept;

    // stall on a bank still being drained, or on a full queue when a request is due
    assign o_rx_ready = !(i_q_full && (r_raw || r_phase == PH_CRC))
                     && !(!r_raw && r_phase == PH_DATA && r_busy[r_wbank]);
    assign w_accept   = i_rx_valid && o_rx_ready;

    always_comb begin
        n_phase    = r_phase;
        n_addr     = r_addr;
        n_len      = r_len;
        n_fill     = r_fill;
        n_crc      = r_crc;
        n_wbank    = r_wbank;
        n_busy     = r_busy;
        o_cmd_push = 1'b0;
        o_cmd      = '0;
        o_mem_wr   = '0;

        if (i_rel.valid) begin
            n_busy[i_rel.bank] = 1'b0;
        end

        if (w_accept) begin
            if (r_raw) begin
                o_cmd_push = 1'b1;
                o_cmd.status = ST_RAW;
                o_cmd.pb     = i_rx_byte;
            end else begin
                case (r_phase)
                    PH_ADDR: begin
                        n_addr  = i_rx_byte;
                        n_phase = PH_LEN;
                    end
                    PH_LEN: begin
                        if (i_rx_byte <= 8'(MAX_PAYLOAD)) begin
                            n_len   = i_rx_byte[LEN_W-1:0];
                            n_fill  = '0;
                            n_crc   = CRC_INIT;
                            n_phase = PH_DATA;
                        end else begin
                            n_phase = PH_HUNT;
                        end
                    end
                    PH_DATA: begin
                        // an empty frame still eats one byte here, not stored
                        if (r_fill < r_len) begin
                            o_mem_wr.valid = 1'b1;
                            o_mem_wr.addr  = {r_wbank, r_fill[IDX_W-1:0]};
                            o_mem_wr.data  = i_rx_byte;
                            n_crc          = crc8_update(r_crc, i_rx_byte);
                        end
                        n_fill = r_fill + 1'b1;
                        if (r_len <= n_fill) begin
                            n_phase = PH_CRC;
                        end
                    end
                    PH_CRC: begin
                        o_cmd_push = 1'b1;
                        o_cmd.addr = r_addr;
                        if (r_crc == i_rx_byte) begin
                            if (r_len == '0) begin
                                o_cmd.status = ST_EMPTY;
                            end else begin
                                o_cmd.status     = ST_PAYLOAD;
                                o_cmd.len        = r_len;
                                o_cmd.crc        = r_crc;
                                o_cmd.bank       = r_wbank;
                                n_busy[r_wbank]  = 1'b1;
                                n_wbank          = !r_wbank;
                            end
                        end else begin
                            o_cmd.status = ST_CRC_ERR;
                            o_cmd.len    = r_len;
                            o_cmd.pb     = i_rx_byte;
                            o_cmd.crc    = r_crc;
                        end
                        n_phase = PH_HUNT;
                    end
                    default: begin
                        n_phase = (i_rx_byte == r_prefix) ? PH_ADDR : PH_HUNT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix <= '0;
            r_raw    <= 1'b0;
            r_phase  <= PH_HUNT;
            r_addr   <= '0;
            r_len    <= '0;
            r_fill   <= '0;
            r_crc    <= CRC_INIT;
            r_wbank  <= 1'b0;
            r_busy   <= '0;
        end else begin
            if (i_cfg_wen) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_PREFIX: r_prefix <= i_cfg_wdata[7:0];
                    CFG_RAW:    r_raw    <= i_cfg_wdata[0];
                    default:    r_raw    <= r_raw;
                endcase
            end
            r_phase <= n_phase;
            r_addr  <= n_addr;
            r_len   <= n_len;
            r_fill  <= n_fill;
            r_crc   <= n_crc;
            r_wbank <= n_wbank;
            r_busy  <= n_busy;
        end
    end

    `SFP_ASSERT_IMP(a_no_write_busy_bank, o_mem_wr.valid, !r_busy[o_mem_wr.addr[IDX_W]], "payload write into a bank awaiting drain")
    `SFP_ASSERT_IMP(a_no_push_full, o_cmd_push, !i_q_full, "request pushed into full queue")
    `SFP_ASSERT_IMP(a_release_busy, i_rel.valid, r_busy[i_rel.bank], "release of a bank that was not busy")
    `SFP_ASSERT_NXT(a_crc_ends_frame, w_accept && !r_raw && r_phase == PH_CRC, r_phase == PH_HUNT, "frame did not end after crc byte")

endmodule

### hdl/sfp_cmdq.sv
// Short request queue between the parser front end and the drain back end.
// Depends on sfp_pkg.
module sfp_cmdq import sfp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    localparam int PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

    t_cmd             r_slot [CMDQ_DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(CMDQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### hdl/sfp_back.sv
// Back end: two-bank payload memory, request execution and the result register.
// Depends on sfp_pkg.
module sfp_back import sfp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_mem_wr          i_mem_wr,
    input  logic             i_q_empty,
    input  t_cmd             i_q_cmd,
    output logic             o_q_pop,
    output t_bank_rel        o_rel,
    output logic             o_valid,
    input  logic             i_ready,
    output t_status          o_status,
    output logic [7:0]       o_addr,
    output logic [LEN_W-1:0] o_len,
    output logic [IDX_W-1:0] o_idx,
    output logic [7:0]       o_pb,
    output logic [7:0]       o_crc,
    output logic             o_last
);

    typedef enum logic [2:0] {
        BK_IDLE  = 3'b001,
        BK_FETCH = 3'b010,
        BK_SHOW  = 3'b100
    } t_bk_state;

    logic [7:0]       r_mem [MEM_DEPTH];
    t_bk_state        r_state, n_state;
    t_cmd             r_cmd;
    logic [IDX_W-1:0] r_idx;
    logic [7:0]       r_rdata;
    logic             w_payload;
    logic             w_more;

    always_ff @(posedge i_clk) begin
        if (i_mem_wr.valid) begin
            r_mem[i_mem_wr.addr] <= i_mem_wr.data;
        end
        if (r_state == BK_FETCH) begin
            r_rdata <= r_mem[{r_cmd.bank, r_idx}];
        end
    end

    assign w_payload = (r_cmd.status == ST_PAYLOAD);
    assign w_more    = w_payload && ((LEN_W'(r_idx) + 1'b1) != r_cmd.len);

    assign o_q_pop   = (r_state == BK_IDLE) && !i_q_empty;
    assign o_valid   = (r_state == BK_SHOW);
    assign o_status  = r_cmd.status;
    assign o_addr    = r_cmd.addr;
    assign o_len     = r_cmd.len;
    assign o_idx     = w_payload ? r_idx : '0;
    assign o_pb      = w_payload ? r_rdata : r_cmd.pb;
    assign o_crc     = r_cmd.crc;
    assign o_last    = !w_more;

    // bank goes back to the parser once its final byte is taken
    assign o_rel.valid = o_valid && i_ready && w_payload && !w_more;
    assign o_rel.bank  = r_cmd.bank;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    n_state = (i_q_cmd.status == ST_PAYLOAD) ? BK_FETCH : BK_SHOW;
                end
            end
            BK_FETCH: n_state = BK_SHOW;
            BK_SHOW: begin
                if (i_ready) begin
                    n_state = w_more ? BK_FETCH : BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_cmd   <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (o_q_pop) begin
                r_cmd <= i_q_cmd;
                r_idx <= '0;
            end else if (r_state == BK_SHOW && i_ready && w_more) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

endmodule

### hdl/spi_frame_parser_crc8_top.sv
// SPI frame parser with CRC-8 check: one SPI byte comes in per request on the slave
// stream. Bytes are deframed as prefix, address, length, payload and CRC (poly 0x07, init 0,
// MSB first). With no stall a byte is taken every cycle. A good frame drains one result
// per payload byte, read in BK_FETCH, then shown in BK_SHOW; status-only and raw results
// go from the queue straight to BK_SHOW. Input stalls only while both payload banks still
// await draining, or on a CRC or raw byte while the two-entry request queue is full.
// Depends on sfp_pkg, sfp_front, sfp_cmdq and sfp_back.
module spi_frame_parser_crc8_top import sfp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wen,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,    // 0 frame_prefix, 1 raw_mode
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [7:0]            i_s_axis_tdata,  // [7:0] rx_byte
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [7:0] frame_address, [13:8] frame_length, [18:14] byte_index,
    // [26:19] payload_byte, [34:27] computed_crc, [39:35] zero
    output logic [39:0]           o_m_axis_tdata,
    output logic [1:0]            o_m_axis_tuser,  // [1:0] status
    output logic                  o_m_axis_tlast
);

    logic             w_push, w_full, w_pop, w_empty;
    t_cmd             w_cmd_in, w_cmd_out;
    t_mem_wr          w_mem_wr;
    t_bank_rel        w_rel;
    t_status          w_status;
    logic [7:0]       w_addr, w_pb, w_crc;
    logic [LEN_W-1:0] w_len;
    logic [IDX_W-1:0] w_idx;

    sfp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rx_valid  (i_s_axis_tvalid),
        .o_rx_ready  (o_s_axis_tready),
        .i_rx_byte   (i_s_axis_tdata),
        .o_cmd_push  (w_push),
        .o_cmd       (w_cmd_in),
        .i_q_full    (w_full),
        .o_mem_wr    (w_mem_wr),
        .i_rel       (w_rel)
    );

    sfp_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_cmd   (w_cmd_out),
        .o_empty (w_empty)
    );

    sfp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_mem_wr  (w_mem_wr),
        .i_q_empty (w_empty),
        .i_q_cmd   (w_cmd_out),
        .o_q_pop   (w_pop),
        .o_rel     (w_rel),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_status  (w_status),
        .o_addr    (w_addr),
        .o_len     (w_len),
        .o_idx     (w_idx),
        .o_pb      (w_pb),
        .o_crc     (w_crc),
        .o_last    (o_m_axis_tlast)
    );

    assign o_m_axis_tuser = w_status;
    assign o_m_axis_tdata = {5'b0, w_crc, w_pb, w_idx, w_len, w_addr};

endmodule

### dv/spi_frame_parser_crc8_top_test.sv
// Self-checking testbench for spi_frame_parser_crc8_top: byte stream in, deframed results out.
// Holds its own frame parser and CRC-8 predictor in a small scoreboard class.
// Depends on sfp_pkg and the RTL of spi_frame_parser_crc8_top.
module spi_frame_parser_crc8_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import sfp_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int MAX_GAP       = 11;
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_BYTES  = 100;

    class frame_scoreboard;
        typedef enum logic [4:0] {
            HUNT_PREFIX = 5'b00001,
            TAKE_ADDR   = 5'b00010,
            TAKE_LEN    = 5'b00100,
            TAKE_DATA   = 5'b01000,
            TAKE_CRC    = 5'b10000
        } t_frame_phase;

        typedef struct packed {
            t_status    status;
            logic [7:0] addr;
            logic [5:0] len;
            logic [4:0] idx;
            logic [7:0] pb;
            logic [7:0] crc;
            logic       last;
        } t_frame_result;

        bit [7:0]      prefix;
        bit            raw_on;
        t_frame_phase  phase;
        bit [7:0]      addr_q;
        int            len_q;
        int            fill_q;
        bit [7:0]      crc_q;
        bit [7:0]      stash [MAX_PAYLOAD];
        t_frame_result expected_q [$];
        int            fail_count;

        function new();
            prefix     = '0;
            raw_on     = 1'b0;
            phase      = HUNT_PREFIX;
            addr_q     = '0;
            len_q      = 0;
            fill_q     = 0;
            crc_q      = '0;
            fail_count = 0;
        endfunction

        // bitwise form: feedback is the top CRC bit xor the incoming data bit
        static function bit [7:0] crc8_step(bit [7:0] c, bit [7:0] d);
            bit fb;
            for (int i = 7; i >= 0; i--) begin
                fb = c[7] ^ d[i];
                c  = {c[6:0], 1'b0} ^ (fb ? 8'h07 : 8'h00);
            end
            return c;
        endfunction

        function void push_result(t_status st, bit [7:0] a, int len, int idx, bit [7:0] pb,
                                  bit [7:0] crc, bit last);
            t_frame_result r;
            r.status = st;
            r.addr   = a;
            r.len    = len[5:0];
            r.idx    = idx[4:0];
            r.pb     = pb;
            r.crc    = crc;
            r.last   = last;
            expected_q.push_back(r);
        endfunction

        // one accepted request on the input stream
        function void note_request(bit [7:0] b);
            if (raw_on) begin
                push_result(ST_RAW, 8'h00, 0, 0, b, 8'h00, 1'b1);
                return;
            end
            case (phase)
                TAKE_ADDR: begin
                    addr_q = b;
                    phase  = TAKE_LEN;
                end
                TAKE_LEN: begin
                    if (b <= MAX_PAYLOAD) begin
                        len_q  = int'(b);
                        fill_q = 0;
                        crc_q  = 8'h00;
                        phase  = TAKE_DATA;
                    end else begin
                        phase = HUNT_PREFIX;
                    end
                end
                TAKE_DATA: begin
                    // an empty frame swallows one byte here without touching the CRC
                    if (fill_q < len_q) begin
                        stash[fill_q[4:0]] = b;
                        crc_q              = crc8_step(crc_q, b);
                    end
                    fill_q++;
                    if (len_q <= fill_q) phase = TAKE_CRC;
                end
                TAKE_CRC: begin
                    if (crc_q != b) begin
                        push_result(ST_CRC_ERR, addr_q, len_q, 0, b, crc_q, 1'b1);
                    end else if (len_q == 0) begin
                        push_result(ST_EMPTY, addr_q, 0, 0, 8'h00, 8'h00, 1'b1);
                    end else begin
                        for (int i = 0; i < len_q; i++) begin
                            push_result(ST_PAYLOAD, addr_q, len_q, i, stash[i[4:0]], crc_q,
                                        i + 1 == len_q);
                        end
                    end
                    phase = HUNT_PREFIX;
                end
                default: begin
                    phase = (b == prefix) ? TAKE_ADDR : HUNT_PREFIX;
                end
            endcase
        endfunction

        function void compare(string what, logic [63:0] exp, logic [63:0] act);
            if (exp !== act) begin
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, exp, act);
                fail_count++;
            end
        endfunction

        function void check_result(logic [39:0] data, logic [1:0] user, logic last);
            t_frame_result e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none actual data %h status %h last %b",
                         $time, data, user, last);
                fail_count++;
                return;
            end
            e = expected_q.pop_front();
            compare("status", 64'(e.status), 64'(user));
            compare("frame_address", 64'(e.addr), 64'(data[7:0]));
            compare("frame_length", 64'(e.len), 64'(data[13:8]));
            compare("byte_index", 64'(e.idx), 64'(data[18:14]));
            compare("payload_byte", 64'(e.pb), 64'(data[26:19]));
            compare("computed_crc", 64'(e.crc), 64'(data[34:27]));
            compare("tdata pad", 64'd0, 64'(data[39:35]));
            compare("last", 64'(e.last), 64'(last));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_wen = 1'b0;
    t_cfg_idx    cfg_idx = CFG_PREFIX;
    logic [7:0]  cfg_wdata = 8'h00;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data = 8'h00;
    logic        s_ready;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [39:0] m_data;
    logic [1:0]  m_user;
    logic        m_last;

    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;

    frame_scoreboard sb = new();

    always #(CLK_HALF) i_clk = ~i_clk;

    spi_frame_parser_crc8_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wen       (cfg_wen),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last)
    );

    // input request is noted before any result of the same edge is checked
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_valid && s_ready) sb.note_request(s_data);
            if (m_valid && m_ready) sb.check_result(m_data, m_user, m_last);
        end
    end

    initial begin
        int gap;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
            @(negedge i_clk);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!m_valid);
        end
    end

    initial begin
        #20ms;
        $display("spi_frame_parser_crc8_top test failed");
        $finish;
    end

    task automatic send_byte(bit [7:0] b);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge i_clk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge i_clk); while (!s_ready);
    endtask

    // drop valid, let every expected result arrive, then give the pipeline time to empty
    task automatic settle();
        @(negedge i_clk) s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, bit [7:0] val);
        @(negedge i_clk);
        cfg_wen   <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        if (idx == CFG_PREFIX) sb.prefix = val;
        else sb.raw_on = val[0];
        @(negedge i_clk) cfg_wen <= 1'b0;
    endtask

    task automatic send_frame(bit [7:0] addr, bit [7:0] len_byte, bit corrupt);
        bit [7:0] crc;
        bit [7:0] pb;
        crc = 8'h00;
        send_byte(sb.prefix);
        send_byte(addr);
        send_byte(len_byte);
        if (len_byte > MAX_PAYLOAD) return;
        if (len_byte == 0) begin
            send_byte(8'($urandom_range(0, 255)));
        end else begin
            for (int i = 0; i < len_byte; i++) begin
                pb  = 8'($urandom_range(0, 255));
                crc = frame_scoreboard::crc8_step(crc, pb);
                send_byte(pb);
            end
        end
        if (corrupt) crc ^= 8'h01 << $urandom_range(0, 7);
        send_byte(crc);
    endtask

    initial begin
        bit [7:0] crc;
        bit [7:0] pb;
        int       sent;
        int       len;
        int       pick;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // directed: reset prefix, empty frames, oversize lengths, bad CRCs, full frame, raw bytes
        send_frame(8'h00, 8'd1, 1'b0);
        send_byte(8'h5A);
        send_frame(8'hFF, 8'd0, 1'b0);
        send_frame(8'h12, 8'd0, 1'b1);
        send_frame(8'h34, 8'd33, 1'b0);
        send_frame(8'h56, 8'd255, 1'b0);
        send_frame(8'h78, 8'd3, 1'b1);
        settle();
        write_reg(CFG_PREFIX, 8'hFF);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        send_frame(8'hA5, 8'd32, 1'b0);
        settle();
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        write_reg(CFG_RAW, 8'h01);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h3C);
        settle();
        write_reg(CFG_RAW, 8'h00);

        // raw mode entered mid-frame must leave the parser where it was
        crc = 8'h00;
        send_byte(sb.prefix);
        send_byte(8'h66);
        send_byte(8'd4);
        for (int i = 0; i < 2; i++) begin
            pb  = 8'($urandom_range(0, 255));
            crc = frame_scoreboard::crc8_step(crc, pb);
            send_byte(pb);
        end
        settle();
        write_reg(CFG_RAW, 8'h01);
        send_byte(8'hC3);
        send_byte(sb.prefix);
        settle();
        write_reg(CFG_RAW, 8'h00);
        for (int i = 0; i < 2; i++) begin
            pb  = 8'($urandom_range(0, 255));
            crc = frame_scoreboard::crc8_step(crc, pb);
            send_byte(pb);
        end
        send_byte(crc);

        // random: mostly well-formed frames, some noise, oversize lengths and bad CRCs
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                settle();
                case ($urandom_range(0, 3))
                    0: write_reg(CFG_PREFIX, 8'h00);
                    1: write_reg(CFG_PREFIX, 8'hFF);
                    default: write_reg(CFG_PREFIX, 8'($urandom_range(0, 255)));
                endcase
                write_reg(CFG_RAW, ($urandom_range(0, 3) == 0) ? 8'h01 : 8'h00);
                tx_steady = ($urandom_range(0, 3) == 0);
                rx_steady = ($urandom_range(0, 3) == 0);
            end else if (pick < 19) begin
                settle();
            end else if (pick < 28) begin
                send_byte(8'($urandom_range(0, 255)));
                sent++;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 70) len = $urandom_range(0, 6);
                else if (pick < 85) len = $urandom_range(7, 20);
                else if (pick < 90) len = MAX_PAYLOAD;
                else len = $urandom_range(MAX_PAYLOAD + 1, 255);
                send_frame(8'($urandom_range(0, 255)), 8'(len), $urandom_range(0, 4) == 0);
                sent += (len > MAX_PAYLOAD) ? 3 : (len == 0) ? 5 : len + 4;
            end
        end

        settle();
        if (sb.fail_count == 0 && sb.expected_q.size() == 0) begin
            $display("spi_frame_parser_crc8_top test passed");
        end else begin
            $display("spi_frame_parser_crc8_top test failed");
        end
        $finish;
    end

endmodule
